[rtl/dotq_pkg.sv]
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared types and constants for the deadline ordered task queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W            = 4;
  localparam int DL_W            = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } entry_t;

endpackage

[rtl/dotq_store.sv]
// ----------------------------------------------------------------------------
// dotq_store
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dotq_store #(
  parameter int QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW          = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  dotq_pkg::entry_t wr_entry,
  input  logic [AW-1:0]    rd_addr,
  output dotq_pkg::entry_t rd_entry
);
  import dotq_pkg::*;

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_addr];
  end

endmodule

[rtl/dotq_seq.sv]
// ----------------------------------------------------------------------------
// dotq_seq
// Request sequencer: walks the slot memory one slot a cycle with a single
// compare unit, shifting entries as it goes, then reports the head.
// ----------------------------------------------------------------------------
module dotq_seq #(
  parameter int QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW          = $clog2(QUEUE_DEPTH),
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fifo_mode,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op,
  input  logic [dotq_pkg::ID_W-1:0] task_id,
  input  logic [dotq_pkg::DL_W-1:0] deadline,
  output logic                      done,
  output logic [1:0]                status,
  output logic [dotq_pkg::ID_W-1:0] out_task_id,
  output logic [dotq_pkg::DL_W-1:0] out_deadline,
  output logic                      head_valid,
  output logic [dotq_pkg::ID_W-1:0] head_task_id,
  output logic [dotq_pkg::DL_W-1:0] head_deadline,
  output logic [CW-1:0]             entry_count,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output dotq_pkg::entry_t          wr_entry,
  output logic [AW-1:0]             rd_addr,
  input  dotq_pkg::entry_t          rd_entry
);
  import dotq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_REM,
    S_HEAD,
    S_RESP
  } state_t;

  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  state_t          state;
  logic [CW-1:0]   occ;
  logic [AW-1:0]   ptr;
  op_t             op_q;
  entry_t          new_q;
  logic            found;
  status_t         status_q;
  entry_t          taken;
  entry_t          carry;

  op_t             op_in;
  entry_t          new_in;
  logic [AW-1:0]   last_idx;
  logic            ins_direct;
  logic            later;
  logic            match;
  logic            last;

  assign op_in      = op_t'(op);
  assign new_in     = '{id: task_id, dl: deadline};
  assign last_idx   = AW'(occ - CW'(1));
  assign ins_direct = fifo_mode || (occ == '0);
  assign later      = new_q.dl < rd_entry.dl;
  assign match      = (op_q == OP_EXTRACT) ? (ptr == '0) : (rd_entry.id == new_q.id);
  assign last       = (ptr == last_idx);
  assign busy       = (state != S_IDLE);

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = ptr;
    wr_entry = new_q;
    rd_addr  = '0;
    unique case (state)
      S_IDLE: begin
        if (start && op_in == OP_INSERT && occ != FULL_CNT) begin
          if (ins_direct) begin
            wr_en    = 1'b1;
            wr_addr  = AW'(occ);
            wr_entry = new_in;
          end
        end
      end
      S_INS: begin
        wr_en    = found || later;
        wr_addr  = ptr;
        wr_entry = found ? carry : new_q;
        rd_addr  = ptr + AW'(1);
      end
      S_INS_PUT: begin
        wr_en    = 1'b1;
        wr_addr  = AW'(occ);
        wr_entry = found ? carry : new_q;
      end
      S_REM: begin
        wr_en    = found;
        wr_addr  = ptr - AW'(1);
        wr_entry = rd_entry;
        rd_addr  = ptr + AW'(1);
      end
      S_HEAD: begin
        rd_addr = '0;
      end
      S_RESP: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q     <= op_in;
            new_q    <= new_in;
            found    <= 1'b0;
            status_q <= ST_OK;
            taken    <= '0;
            priority case (op_in)
              OP_INSERT: begin
                if (occ == FULL_CNT) begin
                  status_q <= ST_FULL;
                  state    <= S_HEAD;
                end else if (ins_direct) begin
                  occ   <= occ + CW'(1);
                  state <= S_HEAD;
                end else begin
                  ptr   <= '0;
                  state <= S_INS;
                end
              end
              OP_EXTRACT, OP_REMOVE: begin
                if (occ == '0) begin
                  status_q <= ST_EMPTY;
                  state    <= S_HEAD;
                end else begin
                  ptr   <= '0;
                  state <= S_REM;
                end
              end
              default: begin
                state <= S_HEAD;
              end
            endcase
          end
        end
        S_INS: begin
          if (found || later) begin
            found <= 1'b1;
            carry <= rd_entry;
          end
          if (last) begin
            state <= S_INS_PUT;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_INS_PUT: begin
          occ   <= occ + CW'(1);
          state <= S_HEAD;
        end
        S_REM: begin
          if (!found && match) begin
            found <= 1'b1;
            taken <= rd_entry;
          end
          if (last) begin
            if (found || match) begin
              occ <= occ - CW'(1);
            end else begin
              status_q <= ST_NOTFOUND;
            end
            state <= S_HEAD;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_HEAD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          done          <= 1'b1;
          status        <= status_q;
          out_task_id   <= taken.id;
          out_deadline  <= taken.dl;
          head_valid    <= (occ != '0);
          head_task_id  <= (occ != '0) ? rd_entry.id : '0;
          head_deadline <= (occ != '0) ? rd_entry.dl : '0;
          entry_count   <= occ;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/deadline_ordered_task_queue.sv]
// ----------------------------------------------------------------------------
// deadline_ordered_task_queue
// Bounded task queue ordered by deadline (ties in arrival order) or FIFO.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on the result ports for one cycle with done high and cannot be
// stalled. A request walks the slots it needs, then reads the head: a sorted
// insert walks every held slot from the head, moving later entries up by one,
// then the tail slot; an extract or remove walks every held slot from the
// head; FIFO inserts and refused requests walk none.
// The walk is set by the slot memory, which moves one entry per cycle.
// fifo_mode may only be written while busy is low and no result is pending.
module deadline_ordered_task_queue #(
  parameter int QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEF,
  parameter int AW          = $clog2(QUEUE_DEPTH),
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op,
  input  logic [dotq_pkg::ID_W-1:0] task_id,
  input  logic [dotq_pkg::DL_W-1:0] deadline,
  output logic                      done,
  output logic [1:0]                status,
  output logic [dotq_pkg::ID_W-1:0] out_task_id,
  output logic [dotq_pkg::DL_W-1:0] out_deadline,
  output logic                      head_valid,
  output logic [dotq_pkg::ID_W-1:0] head_task_id,
  output logic [dotq_pkg::DL_W-1:0] head_deadline,
  output logic [CW-1:0]             entry_count
);
  import dotq_pkg::*;

  logic          fifo_mode;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_entry;
  logic [AW-1:0] rd_addr;
  entry_t        rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_mode <= 1'b0;
    end else if (cfg_we) begin
      fifo_mode <= cfg_wdata;
    end
  end

  dotq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .fifo_mode     (fifo_mode),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .task_id       (task_id),
    .deadline      (deadline),
    .done          (done),
    .status        (status),
    .out_task_id   (out_task_id),
    .out_deadline  (out_deadline),
    .head_valid    (head_valid),
    .head_task_id  (head_task_id),
    .head_deadline (head_deadline),
    .entry_count   (entry_count),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_entry      (wr_entry),
    .rd_addr       (rd_addr),
    .rd_entry      (rd_entry)
  );

  dotq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

endmodule

[verif/dotq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dotq_checker
// Watches the request, result and register ports of the task queue, keeps
// its own copy of the slot array and the mode bit, and checks each result
// field by field against the outcome worked out when its request was taken.
// ----------------------------------------------------------------------------
module dotq_checker #(
  parameter int DEPTH = dotq_pkg::QUEUE_DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                op,
  input  logic [dotq_pkg::ID_W-1:0] task_id,
  input  logic [dotq_pkg::DL_W-1:0] deadline,
  input  logic                      done,
  input  logic [1:0]                status,
  input  logic [dotq_pkg::ID_W-1:0] out_task_id,
  input  logic [dotq_pkg::DL_W-1:0] out_deadline,
  input  logic                      head_valid,
  input  logic [dotq_pkg::ID_W-1:0] head_task_id,
  input  logic [dotq_pkg::DL_W-1:0] head_deadline,
  input  logic [CW-1:0]             entry_count,
  output int                        pending,
  output int                        fail_count
);
  import dotq_pkg::*;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] taken_id;
    logic [DL_W-1:0] taken_dl;
    logic            head_valid;
    logic [ID_W-1:0] head_id;
    logic [DL_W-1:0] head_dl;
    logic [CW-1:0]   count;
  } outcome_t;

  logic [ID_W-1:0] slot_id [DEPTH];
  logic [DL_W-1:0] slot_dl [DEPTH];
  int              held;
  logic            fifo_mode;
  outcome_t        awaited_outcomes[$];
  int              mismatches;

  assign fail_count = mismatches;

  // close the gap left by slot pos; later entries move towards the head
  function automatic void unlink_slot(int pos);
    int i;
    for (i = pos; i < held - 1; i++) begin
      slot_id[i] = slot_id[i + 1];
      slot_dl[i] = slot_dl[i + 1];
    end
    held--;
  endfunction

  function automatic outcome_t predict_outcome(logic [1:0] opc, logic [ID_W-1:0] id,
                                               logic [DL_W-1:0] dl);
    outcome_t r;
    int       i;
    int       pos;
    r = '0;
    r.status = ST_OK;
    case (opc)
      OP_INSERT: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = held;
          // sorted: ahead of the first entry with a strictly later deadline
          if (!fifo_mode) begin
            for (i = held - 1; i >= 0; i--) begin
              if (dl < slot_dl[i]) pos = i;
            end
          end
          for (i = held; i > pos; i--) begin
            slot_id[i] = slot_id[i - 1];
            slot_dl[i] = slot_dl[i - 1];
          end
          slot_id[pos] = id;
          slot_dl[pos] = dl;
          held++;
        end
      end
      OP_EXTRACT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.taken_id = slot_id[0];
          r.taken_dl = slot_dl[0];
          unlink_slot(0);
        end
      end
      OP_REMOVE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = held;
          for (i = held - 1; i >= 0; i--) begin
            if (slot_id[i] == id) pos = i;
          end
          if (pos >= held) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.taken_id = slot_id[pos];
            r.taken_dl = slot_dl[pos];
            unlink_slot(pos);
          end
        end
      end
      default: ;
    endcase
    if (held > 0) begin
      r.head_valid = 1'b1;
      r.head_id    = slot_id[0];
      r.head_dl    = slot_dl[0];
    end
    r.count = CW'(held);
    return r;
  endfunction

  task automatic check_field(string name, logic [DL_W-1:0] exp_v, logic [DL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
  end

  always @(posedge clk) begin
    outcome_t ex;
    if (rst) begin
      held      = 0;
      fifo_mode = 1'b0;
      awaited_outcomes.delete();
      for (int i = 0; i < DEPTH; i++) begin
        slot_id[i] = '0;
        slot_dl[i] = '0;
      end
    end else begin
      if (done) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual status 0x%0h",
                   $time, status);
          mismatches++;
        end else begin
          ex = awaited_outcomes.pop_front();
          check_field("status", DL_W'(ex.status), DL_W'(status));
          check_field("out_task_id", DL_W'(ex.taken_id), DL_W'(out_task_id));
          check_field("out_deadline", ex.taken_dl, out_deadline);
          check_field("head_valid", DL_W'(ex.head_valid), DL_W'(head_valid));
          check_field("head_task_id", DL_W'(ex.head_id), DL_W'(head_task_id));
          check_field("head_deadline", ex.head_dl, head_deadline);
          check_field("entry_count", DL_W'(ex.count), DL_W'(entry_count));
        end
      end
      if (cfg_we) fifo_mode = cfg_wdata;
      if (start && !busy) awaited_outcomes.push_back(predict_outcome(op, task_id, deadline));
    end
    pending <= awaited_outcomes.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the deadline ordered task queue: a directed pass over the
// corner cases, then random phases in both modes with varied request gaps.
// Checking is done by dotq_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import dotq_pkg::*;

  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_wdata;
  logic              start;
  logic              busy;
  logic [1:0]        op;
  logic [ID_W-1:0]   task_id;
  logic [DL_W-1:0]   deadline;
  logic              done;
  logic [1:0]        status;
  logic [ID_W-1:0]   out_task_id;
  logic [DL_W-1:0]   out_deadline;
  logic              head_valid;
  logic [ID_W-1:0]   head_task_id;
  logic [DL_W-1:0]   head_deadline;
  logic [CW-1:0]     entry_count;
  int                pending;
  int                fail_count;
  int                idle_pct;
  int                cycle_count = 0;

  deadline_ordered_task_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .op(op), .task_id(task_id), .deadline(deadline),
    .done(done), .status(status), .out_task_id(out_task_id), .out_deadline(out_deadline),
    .head_valid(head_valid), .head_task_id(head_task_id), .head_deadline(head_deadline),
    .entry_count(entry_count)
  );

  dotq_checker #(.DEPTH(QUEUE_DEPTH)) u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .op(op), .task_id(task_id), .deadline(deadline),
    .done(done), .status(status), .out_task_id(out_task_id), .out_deadline(out_deadline),
    .head_valid(head_valid), .head_task_id(head_task_id), .head_deadline(head_deadline),
    .entry_count(entry_count), .pending(pending), .fail_count(fail_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("deadline_ordered_task_queue test failed");
      $finish;
    end
  end

  // start stays high across back-to-back requests; it only drops in a gap
  task automatic send_request(input logic [1:0] opc, input logic [ID_W-1:0] id,
                              input logic [DL_W-1:0] dl);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    op       <= opc;
    task_id  <= id;
    deadline <= dl;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (QUEUE_DEPTH + 3) @(posedge clk);
  endtask

  task automatic write_mode(input logic fifo);
    cfg_we    <= 1'b1;
    cfg_wdata <= fifo;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_request(input mix_t mix);
    int              roll;
    logic [1:0]      opc;
    logic [DL_W-1:0] dl;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      opc = OP_NOP;
    end else if (mix == MIX_FILL) begin
      opc = (roll < 85) ? OP_INSERT : ($urandom_range(0, 1) ? OP_EXTRACT : OP_REMOVE);
    end else if (mix == MIX_DRAIN) begin
      opc = (roll < 20) ? OP_INSERT : ($urandom_range(0, 1) ? OP_EXTRACT : OP_REMOVE);
    end else begin
      opc = (roll < 50) ? OP_INSERT : ($urandom_range(0, 1) ? OP_EXTRACT : OP_REMOVE);
    end
    roll = $urandom_range(0, 9);
    if (roll < 5) begin
      dl = $urandom_range(0, 7);
    end else if (roll < 7) begin
      case ($urandom_range(0, 3))
        0: dl = '0;
        1: dl = '1;
        2: dl = 32'h8000_0000;
        default: dl = 32'h7FFF_FFFF;
      endcase
    end else begin
      dl = $urandom;
    end
    send_request(opc, ID_W'($urandom_range(0, 15)), dl);
  endtask

  initial begin
    int   p;
    int   n;
    int   left;
    mix_t mix;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_wdata   <= 1'b0;
    start       <= 1'b0;
    op          <= OP_NOP;
    task_id     <= '0;
    deadline    <= '0;
    idle_pct    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pass, sorted mode
    write_mode(1'b0);
    send_request(OP_EXTRACT, 4'd0, 32'd0);
    send_request(OP_REMOVE, 4'd5, 32'd0);
    send_request(OP_NOP, 4'd15, '1);
    send_request(OP_INSERT, 4'd3, 32'd100);
    send_request(OP_INSERT, 4'd7, 32'd100);
    send_request(OP_INSERT, 4'd15, 32'd0);
    send_request(OP_INSERT, 4'd0, '1);
    send_request(OP_INSERT, 4'd9, 32'd50);
    send_request(OP_INSERT, 4'd3, 32'd100);
    send_request(OP_REMOVE, 4'd12, 32'd0);
    send_request(OP_REMOVE, 4'd3, 32'd0);
    send_request(OP_NOP, 4'd0, 32'd0);
    send_request(OP_EXTRACT, 4'd0, 32'd0);
    send_request(OP_INSERT, 4'd5, 32'd0);
    send_request(OP_REMOVE, 4'd0, 32'd0);
    repeat (5) send_request(OP_EXTRACT, 4'd0, 32'd0);
    settle();

    // random phases: mode alternates, gaps cycle through none, heavy, moderate
    for (p = 0; p < PHASES; p++) begin
      write_mode(p[0]);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 69;
        default: idle_pct = 36;
      endcase
      left = 0;
      mix  = MIX_EVEN;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (left == 0) begin
          mix  = mix_t'($urandom_range(0, 2));
          left = $urandom_range(8, 40);
        end
        random_request(mix);
        left--;
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("deadline_ordered_task_queue test passed");
    end else begin
      $display("deadline_ordered_task_queue test failed");
    end
    $finish;
  end

endmodule
